@@ sv/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and fixed-point helpers for the tridiagonal solver.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int DW        = 48;
  localparam int FRAC_BITS = 32;
  localparam int MAX_ROWS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = ROW_W + 1;
  localparam int MEM_W     = 2 * DW;

  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ROWS = 2'd2;

  // result of an arithmetic unit
  typedef struct packed {
    logic                 done;
    logic                 ovf;
    logic signed [DW-1:0] val;
  } res_t;

  // magnitude of a signed value, full range fits unsigned
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // apply sign to a magnitude, clip to the signed range
  function automatic res_t apply_sign(input logic [DW:0] m, input logic big,
                                      input logic neg);
    res_t r;
    r.done = 1'b0;
    if (neg) begin
      r.ovf = big || (m > {2'b01, {(DW-1){1'b0}}});
      r.val = r.ovf ? VAL_MIN : (~m[DW-1:0] + 1'b1);
    end else begin
      r.ovf = big || (m >= {2'b01, {(DW-1){1'b0}}});
      r.val = r.ovf ? VAL_MAX : m[DW-1:0];
    end
    apply_sign = r;
  endfunction

  // saturating subtract a - b
  function automatic res_t sat_sub(input logic signed [DW-1:0] a,
                                   input logic signed [DW-1:0] b);
    res_t       r;
    logic [DW:0] d;
    d      = {a[DW-1], a} - {b[DW-1], b};
    r.done = 1'b0;
    r.ovf  = d[DW] != d[DW-1];
    r.val  = r.ovf ? (d[DW] ? VAL_MIN : VAL_MAX) : d[DW-1:0];
    sat_sub = r;
  endfunction

endpackage

@@ sv/tss_mem.sv @@
// ----------------------------------------------------------------------------
// tss_mem
// Row store: upper ratio and right-hand side (later solution) per row.
// ----------------------------------------------------------------------------
module tss_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [tss_pkg::ROW_W-1:0] waddr,
  input  logic [tss_pkg::MEM_W-1:0] wdata,
  input  logic                      re,
  input  logic [tss_pkg::ROW_W-1:0] raddr,
  output logic [tss_pkg::MEM_W-1:0] rdata
);
  import tss_pkg::*;

  logic [MEM_W-1:0] mem [MAX_ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tss_mul.sv @@
// ----------------------------------------------------------------------------
// tss_mul
// Fixed-point multiplier, four 24x24 partial products accumulated in turn.
// ----------------------------------------------------------------------------
module tss_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic signed [tss_pkg::DW-1:0] a,
  input  logic signed [tss_pkg::DW-1:0] b,
  output tss_pkg::res_t               res
);
  import tss_pkg::*;

  localparam int HW   = DW / 2;
  localparam int ACCW = 2 * DW;

  logic            busy_r, busy_nxt;
  logic            fin_r, fin_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;
  logic [DW-1:0]   ma_r, ma_nxt, mb_r, mb_nxt;
  logic [ACCW-1:0] acc_r, acc_nxt;
  res_t            res_r, res_nxt;
  logic [HW-1:0]   ah, bh;
  logic [DW-1:0]   pp;
  logic [7:0]      shamt;
  logic [ACCW-1:0] pshift;

  // partial product select
  always_comb begin
    ah     = cnt_r[0] ? ma_r[DW-1:HW] : ma_r[HW-1:0];
    bh     = cnt_r[1] ? mb_r[DW-1:HW] : mb_r[HW-1:0];
    pp     = DW'(ah) * DW'(bh);
    shamt  = 8'(HW) * (8'(cnt_r[0]) + 8'(cnt_r[1]));
    pshift = ACCW'(pp) << shamt;
  end

  // step control
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    res_nxt.done = 1'b0;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
      neg_nxt  = a[DW-1] ^ b[DW-1];
      ma_nxt   = mag(a);
      mb_nxt   = mag(b);
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + pshift;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      res_nxt = apply_sign(acc_r[FRAC_BITS +: DW+1],
                           |acc_r[ACCW-1:FRAC_BITS+DW+1], neg_r);
      res_nxt.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      fin_r        <= 1'b0;
      res_r.done   <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      fin_r        <= fin_nxt;
      res_r.done   <= res_nxt.done;
    end
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    acc_r     <= acc_nxt;
    res_r.ovf <= res_nxt.ovf;
    res_r.val <= res_nxt.val;
  end

  assign res = res_r;

endmodule

@@ sv/tss_div.sv @@
// ----------------------------------------------------------------------------
// tss_div
// Fixed-point divider, restoring, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tss_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic signed [tss_pkg::DW-1:0] n,
  input  logic signed [tss_pkg::DW-1:0] d,
  output tss_pkg::res_t                 res
);
  import tss_pkg::*;

  localparam int DVE   = 2 * ((DW + FRAC_BITS + 1) / 2);
  localparam int NCYC  = DVE / 2;
  localparam int CW    = $clog2(NCYC + 1);

  logic           busy_r, busy_nxt;
  logic           fin_r, fin_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           neg_r, neg_nxt;
  logic [DW-1:0]  md_r, md_nxt;
  logic [DVE-1:0] dv_r, dv_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW:0]    q_r, q_nxt;
  logic           stk_r, stk_nxt;
  res_t           res_r, res_nxt;
  logic [DW:0]    rt;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    md_nxt   = md_r;
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    stk_nxt  = stk_r;
    rt       = '0;
    res_nxt  = res_r;
    res_nxt.done = 1'b0;
    if (go) begin
      if (d == '0) begin
        // zero pivot: clip toward the sign of the numerator
        res_nxt.done = 1'b1;
        res_nxt.ovf  = 1'b1;
        res_nxt.val  = (n == '0) ? '0 : (n[DW-1] ? VAL_MIN : VAL_MAX);
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        neg_nxt  = n[DW-1] ^ d[DW-1];
        md_nxt   = mag(d);
        dv_nxt   = DVE'(mag(n)) << FRAC_BITS;
        rem_nxt  = '0;
        q_nxt    = '0;
        stk_nxt  = 1'b0;
      end
    end else if (busy_r) begin
      // two restoring steps
      for (int j = 0; j < 2; j++) begin
        rt      = {rem_nxt, dv_nxt[DVE-1]};
        dv_nxt  = dv_nxt << 1;
        stk_nxt = stk_nxt | q_nxt[DW];
        if (rt >= {1'b0, md_r}) begin
          rt    = rt - {1'b0, md_r};
          q_nxt = {q_nxt[DW-1:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[DW-1:0], 1'b0};
        end
        rem_nxt = rt[DW-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NCYC - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      res_nxt = apply_sign(q_r, stk_r, neg_r);
      res_nxt.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      fin_r      <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      fin_r      <= fin_nxt;
      res_r.done <= res_nxt.done;
    end
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    md_r      <= md_nxt;
    dv_r      <= dv_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    stk_r     <= stk_nxt;
    res_r.ovf <= res_nxt.ovf;
    res_r.val <= res_nxt.val;
  end

  assign res = res_r;

endmodule

@@ sv/tridiagonal_system_solver.sv @@
// ----------------------------------------------------------------------------
// tridiagonal_system_solver
// Thomas-algorithm solver for tridiagonal systems in signed Q16.32.
// ----------------------------------------------------------------------------
// Rows enter one item at a time; each row passes through the pair of
// two-bit-per-cycle dividers, and every row but the first passes first
// through the four-step multipliers. A row arriving at a full store is
// dropped. The row flagged last starts back substitution, per row a row
// store read, a multiply and a write back, then the solution leaves in
// index order, one row store read per result, while the output is not
// stalled. The input stalls from acceptance of a row until its work is
// done. Status reports zero pivot or overflow (1) and dropped rows beyond
// 64 (2).
module tridiagonal_system_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tss_pkg::DW-1:0] in_lower_coef,
  input  logic signed [tss_pkg::DW-1:0] in_diag_coef,
  input  logic signed [tss_pkg::DW-1:0] in_upper_coef,
  input  logic signed [tss_pkg::DW-1:0] in_rhs_value,
  input  logic                          in_last_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [tss_pkg::DW-1:0] out_solution,
  output logic [tss_pkg::ROW_W-1:0]     out_row_index,
  output logic                          out_last_result,
  output logic [1:0]                    out_status
);
  import tss_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_MULW    = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_DIVW    = 4'd4;
  localparam logic [3:0] S_BS_CHK  = 4'd5;
  localparam logic [3:0] S_BS_RD   = 4'd6;
  localparam logic [3:0] S_BS_MUL  = 4'd7;
  localparam logic [3:0] S_BS_MULW = 4'd8;
  localparam logic [3:0] S_EM_RD   = 4'd9;
  localparam logic [3:0] S_EM_LD   = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     rows_r, rows_nxt;
  logic [1:0]           err_r, err_nxt;
  logic signed [DW-1:0] lower_r, lower_nxt, diag_r, diag_nxt;
  logic signed [DW-1:0] upper_r, upper_nxt, rhs_r, rhs_nxt;
  logic                 last_r, last_nxt;
  logic signed [DW-1:0] pivot_r, pivot_nxt, num_r, num_nxt;
  logic signed [DW-1:0] prev_u_r, prev_u_nxt, prev_r_r, prev_r_nxt;
  logic signed [DW-1:0] x_r, x_nxt;
  logic [ROW_W-1:0]     k_r, k_nxt, e_r, e_nxt, last_idx;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_sol_r, out_sol_nxt;
  logic [ROW_W-1:0]     out_idx_r, out_idx_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [1:0]           out_st_r, out_st_nxt;
  logic                 ovf;
  logic                 load;

  // arithmetic units and row store
  logic                 mul_go, div_go;
  logic signed [DW-1:0] mul0_a, mul0_b;
  res_t                 mul0_res, mul1_res, div0_res, div1_res;
  res_t                 sa, sb;
  logic                 mem_we, mem_re;
  logic [ROW_W-1:0]     mem_waddr, mem_raddr;
  logic [MEM_W-1:0]     mem_wdata, mem_rdata;
  logic signed [DW-1:0] rd_u, rd_r;

  assign rd_u     = mem_rdata[MEM_W-1:DW];
  assign rd_r     = mem_rdata[DW-1:0];
  assign last_idx = ROW_W'(rows_r - 1'b1);
  assign mul0_a   = (state_r == S_BS_MUL) ? rd_u : lower_r;
  assign mul0_b   = (state_r == S_BS_MUL) ? x_r : prev_u_r;

  tss_mul u_mul0 (.clk(clk), .rst_n(rst_n), .go(mul_go), .a(mul0_a), .b(mul0_b),
                  .res(mul0_res));
  tss_mul u_mul1 (.clk(clk), .rst_n(rst_n), .go(mul_go), .a(lower_r), .b(prev_r_r),
                  .res(mul1_res));
  tss_div u_div0 (.clk(clk), .rst_n(rst_n), .go(div_go), .n(upper_r), .d(pivot_r),
                  .res(div0_res));
  tss_div u_div1 (.clk(clk), .rst_n(rst_n), .go(div_go), .n(num_r), .d(pivot_r),
                  .res(div1_res));
  tss_mem u_mem (.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
                 .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rows_nxt   = rows_r;
    err_nxt    = err_r;
    lower_nxt  = lower_r;
    diag_nxt   = diag_r;
    upper_nxt  = upper_r;
    rhs_nxt    = rhs_r;
    last_nxt   = last_r;
    pivot_nxt  = pivot_r;
    num_nxt    = num_r;
    prev_u_nxt = prev_u_r;
    prev_r_nxt = prev_r_r;
    x_nxt      = x_r;
    k_nxt      = k_r;
    e_nxt      = e_r;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    ovf        = 1'b0;
    load       = 1'b0;
    sa         = sat_sub(diag_r, mul0_res.val);
    sb         = sat_sub(rhs_r, mul1_res.val);
    out_valid_nxt = out_valid_r & out_stall;
    out_sol_nxt   = out_sol_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lower_nxt = in_lower_coef;
          diag_nxt  = in_diag_coef;
          upper_nxt = in_upper_coef;
          rhs_nxt   = in_rhs_value;
          last_nxt  = in_last_row;
          if (rows_r == CNT_W'(MAX_ROWS)) begin
            // full store: drop the row
            err_nxt = ST_ROWS;
            if (in_last_row) begin
              k_nxt     = ROW_W'(MAX_ROWS - 1);
              x_nxt     = prev_r_r;
              state_nxt = S_BS_CHK;
            end
          end else if (rows_r == '0) begin
            pivot_nxt = in_diag_coef;
            num_nxt   = in_rhs_value;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        mul_go    = 1'b1;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        if (mul1_res.done) begin
          pivot_nxt = sa.val;
          num_nxt   = sb.val;
          ovf       = mul0_res.ovf | mul1_res.ovf | sa.ovf | sb.ovf;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_go    = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div1_res.done) begin
          ovf        = div1_res.ovf | (!last_r & div0_res.ovf);
          prev_u_nxt = last_r ? '0 : div0_res.val;
          prev_r_nxt = div1_res.val;
          mem_we     = 1'b1;
          mem_waddr  = rows_r[ROW_W-1:0];
          mem_wdata  = {prev_u_nxt, div1_res.val};
          rows_nxt   = rows_r + 1'b1;
          if (last_r) begin
            k_nxt     = rows_r[ROW_W-1:0];
            x_nxt     = div1_res.val;
            state_nxt = S_BS_CHK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_BS_CHK: begin
        if (k_r == '0) begin
          e_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_BS_RD;
        end
      end
      S_BS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = k_r - 1'b1;
        state_nxt = S_BS_MUL;
      end
      S_BS_MUL: begin
        mul_go    = 1'b1;
        state_nxt = S_BS_MULW;
      end
      S_BS_MULW: begin
        // x[k-1] = r[k-1] - u[k-1] * x[k], written over r[k-1]
        sa = sat_sub(rd_r, mul0_res.val);
        if (mul0_res.done) begin
          ovf       = mul0_res.ovf | sa.ovf;
          mem_we    = 1'b1;
          mem_waddr = k_r - 1'b1;
          mem_wdata = {rd_u, sa.val};
          x_nxt     = sa.val;
          k_nxt     = k_r - 1'b1;
          state_nxt = S_BS_CHK;
        end
      end
      S_EM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = e_r;
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        if (!out_valid_r || !out_stall) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          out_sol_nxt   = rd_r;
          out_idx_nxt   = e_r;
          out_last_nxt  = (e_r == last_idx);
          out_st_nxt    = err_r;
          if (e_r == last_idx) begin
            rows_nxt  = '0;
            err_nxt   = ST_OK;
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r + 1'b1;
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // overflow marks status unless rows were already dropped
    if (ovf && err_r == ST_OK) begin
      err_nxt = ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lower_r    <= lower_nxt;
    diag_r     <= diag_nxt;
    upper_r    <= upper_nxt;
    rhs_r      <= rhs_nxt;
    last_r     <= last_nxt;
    pivot_r    <= pivot_nxt;
    num_r      <= num_nxt;
    prev_u_r   <= prev_u_nxt;
    prev_r_r   <= prev_r_nxt;
    x_r        <= x_nxt;
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    out_sol_r  <= out_sol_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_solution    = out_sol_r;
  assign out_row_index   = out_idx_r;
  assign out_last_result = out_last_r;
  assign out_status      = out_st_r;

`ifndef SYNTHESIS
  // row count never exceeds the store
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= CNT_W'(MAX_ROWS))
    else $error("row count beyond store depth");

  // a row arriving at a full store flags too many rows
  a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && rows_r == CNT_W'(MAX_ROWS)) |=> err_r == ST_ROWS)
    else $error("dropped row not reported");

  // final result of a solve clears the system state
  a_solve_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (load && e_r == last_idx) |=> (rows_r == '0 && err_r == ST_OK))
    else $error("state not cleared after solve");
`endif

endmodule
